### hdl/met_pkg.sv
// shared types, widths and register codes of the escape-time pixel unit
`timescale 1ns / 1ps
package met_pkg;

   // fixed-point format and image size
   localparam int FRAC_BITS = 28;
   localparam int MAX_DIM   = 4096;

   // field widths
   localparam int COORD_W   = 12;
   localparam int C_W       = 32;
   localparam int STEP_W    = 31;
   localparam int LIMIT_W   = 16;
   localparam int COUNT_W   = 16;
   localparam int COLOR_W   = 8;
   localparam int REQ_W     = 2 * COORD_W;
   localparam int RSP_W     = 2 * COORD_W + COUNT_W + COLOR_W;

   // datapath widths
   // z stays within +-2.0 between steps, so F+3 bits hold it
   localparam int Z_W       = FRAC_BITS + 3;
   localparam int P_W       = 2 * Z_W;
   localparam int N_W       = ((Z_W > C_W) ? Z_W : C_W) + 3;
   localparam int FP_W      = COORD_W + STEP_W;
   localparam int CS_W      = FP_W + 2;

   // front-to-back queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // register file
   localparam int REG_INDEX_W = 3;
   localparam int ADDR_W      = REG_INDEX_W + 2;
   localparam int DATA_W      = 32;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);

   typedef enum logic [REG_INDEX_W-1:0] {
      REG_MIN_REAL,
      REG_MAX_IMAG,
      REG_REAL_STEP,
      REG_IMAG_STEP,
      REG_ITER_LIMIT
   } reg_index_type;

   typedef struct packed {
      logic signed [C_W-1:0] min_real;
      logic signed [C_W-1:0] max_imag;
      logic [STEP_W-1:0]     real_step;
      logic [STEP_W-1:0]     imag_step;
   } cfg_type;

   typedef struct packed {
      logic [COORD_W-1:0]    column;
      logic [COORD_W-1:0]    row;
      logic signed [C_W-1:0] c_re;
      logic signed [C_W-1:0] c_im;
   } job_type;

endpackage

### hdl/mandelbrot_escape_time_pixel_unit.sv
// top level of the escape-time pixel unit: register file and front/queue/core
`timescale 1ns / 1ps
// usage
//  - req channel: one transfer per pixel, column in tdata[11:0], row in tdata[23:12]
//  - rsp channel: one transfer per pixel, in request order, carrying the
//    coordinates back with escape count and colour index
//  - csr port: five registers at byte addresses 0,4,..,16 (left edge, top
//    edge, column step, row step, iteration limit); write only while idle
//  - front end takes a request every cycle while its stage or the two-entry
//    queue has room; c is formed from the registered products of its stage
//  - the core makes one complex step per cycle; for each pixel it pops a job
//    in its idle state, steps until the magnitude test, the iteration limit
//    or the box test ends the pixel, then loads the result in its done state
//  - the result sits in an output register, so the core starts the next
//    pixel while the receiver stalls; it waits only when a second result is
//    finished before the first is taken
//  - reset empties the pipeline and sets the registers to zero, with the
//    iteration limit at 256
module mandelbrot_escape_time_pixel_unit (
   input  logic                          clock,
   input  logic                          reset,
   // pixel requests
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [met_pkg::REQ_W-1:0]     req_tdata,   // column, row
   // results
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [met_pkg::RSP_W-1:0]     rsp_tdata,   // pixel_column, pixel_row,
                                                      // escape_count, color_index
   // register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [met_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [met_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [met_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import met_pkg::*;

   // configuration registers
   logic signed [C_W-1:0] min_real_ff, max_imag_ff;
   logic [STEP_W-1:0]     real_step_ff, imag_step_ff;
   logic [LIMIT_W-1:0]    iter_limit_ff;
   logic                  csr_write;
   reg_index_type         csr_index;
   cfg_type               cfg;

   // front to queue to core
   logic                  push_valid, queue_full, queue_empty, job_pop;
   job_type               push_job, head_job;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_real_ff   <= '0;
         max_imag_ff   <= '0;
         real_step_ff  <= '0;
         imag_step_ff  <= '0;
         iter_limit_ff <= LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MIN_REAL:   min_real_ff   <= csr_pwdata[C_W-1:0];
            REG_MAX_IMAG:   max_imag_ff   <= csr_pwdata[C_W-1:0];
            REG_REAL_STEP:  real_step_ff  <= csr_pwdata[STEP_W-1:0];
            REG_IMAG_STEP:  imag_step_ff  <= csr_pwdata[STEP_W-1:0];
            REG_ITER_LIMIT: iter_limit_ff <= csr_pwdata[LIMIT_W-1:0];
            default: ;   // addresses past the register list are ignored
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (csr_index)
         REG_MIN_REAL:   csr_prdata = DATA_W'(min_real_ff);
         REG_MAX_IMAG:   csr_prdata = DATA_W'(max_imag_ff);
         REG_REAL_STEP:  csr_prdata = DATA_W'(real_step_ff);
         REG_IMAG_STEP:  csr_prdata = DATA_W'(imag_step_ff);
         REG_ITER_LIMIT: csr_prdata = DATA_W'(iter_limit_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.min_real  = min_real_ff;
      cfg.max_imag  = max_imag_ff;
      cfg.real_step = real_step_ff;
      cfg.imag_step = imag_step_ff;
   end

   // front end: clamp coordinates, scale by the steps, offset and saturate
   met_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_full  (queue_full),
      .push_job   (push_job)
   );

   // lets the front end keep taking requests while the core iterates
   met_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (job_pop),
      .empty      (queue_empty),
      .head       (head_job)
   );

   // iteration core with its output register
   met_core u_core (
      .clock           (clock),
      .reset           (reset),
      .iteration_limit (iter_limit_ff),
      .job_valid       (!queue_empty),
      .job_pop         (job_pop),
      .job             (head_job),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata)
   );

endmodule

### hdl/met_front.sv
// front end: accepts pixel requests and forms the complex constant c
`timescale 1ns / 1ps
module met_front (
   input  logic                         clock,
   input  logic                         reset,
   input  met_pkg::cfg_type             cfg,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [met_pkg::REQ_W-1:0]    req_tdata,   // column, row
   output logic                         push_valid,
   input  logic                         push_full,
   output met_pkg::job_type             push_job
);
   import met_pkg::*;

   logic                 stage_valid_ff, stage_valid_in;
   logic [COORD_W-1:0]   col_ff, col_in;
   logic [COORD_W-1:0]   row_ff, row_in;
   logic [FP_W-1:0]      re_prod_ff, re_prod_in;
   logic [FP_W-1:0]      im_prod_ff, im_prod_in;
   logic [COORD_W-1:0]   cx, cy;
   logic                 accept;
   logic signed [CS_W-1:0] re_sum, im_sum;

   // saturate to the signed register range
   function automatic logic signed [C_W-1:0] sat_c(input logic signed [CS_W-1:0] v);
      logic signed [C_W-1:0] r;
      if (v[CS_W-1:C_W-1] == {(CS_W-C_W+1){v[CS_W-1]}}) begin
         r = v[C_W-1:0];
      end else if (v[CS_W-1]) begin
         r = {1'b1, {(C_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(C_W-1){1'b1}}};
      end
      return r;
   endfunction

   assign req_tready = !stage_valid_ff || !push_full;
   assign accept     = req_tvalid && req_tready;
   assign push_valid = stage_valid_ff && !push_full;

   always_comb begin
      col_in = req_tdata[COORD_W-1:0];
      row_in = req_tdata[2*COORD_W-1:COORD_W];
      // coordinates beyond the image clamp to the last column or row
      cx = (int'(col_in) >= MAX_DIM) ? COORD_W'(MAX_DIM - 1) : col_in;
      cy = (int'(row_in) >= MAX_DIM) ? COORD_W'(MAX_DIM - 1) : row_in;
      re_prod_in = FP_W'(cx) * FP_W'(cfg.real_step);
      im_prod_in = FP_W'(cy) * FP_W'(cfg.imag_step);
      stage_valid_in = accept ? 1'b1 : (push_valid ? 1'b0 : stage_valid_ff);
   end

   always_comb begin
      re_sum = CS_W'($signed(cfg.min_real)) + $signed({2'b00, re_prod_ff});
      im_sum = CS_W'($signed(cfg.max_imag)) - $signed({2'b00, im_prod_ff});
      push_job.column = col_ff;
      push_job.row    = row_ff;
      push_job.c_re   = sat_c(re_sum);
      push_job.c_im   = sat_c(im_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      if (accept) begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         re_prod_ff <= re_prod_in;
         im_prod_ff <= im_prod_in;
      end
   end

endmodule

### hdl/met_queue.sv
// short job queue between front end and iteration core
`timescale 1ns / 1ps
module met_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  met_pkg::job_type  push_job,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output met_pkg::job_type  head
);
   import met_pkg::*;

   job_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   function automatic logic [QUEUE_PTR_W-1:0] ptr_next(input logic [QUEUE_PTR_W-1:0] p);
      return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_PTR_W'(1);
   endfunction

   assign full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      pop && !push_valid |=> count_ff == $past(count_ff) - QUEUE_CNT_W'(1))
      else $error("pop without push did not reduce fill count");

endmodule

### hdl/met_core.sv
// back end: iterates z = z^2 + c one step per cycle and holds the result
`timescale 1ns / 1ps
module met_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [met_pkg::LIMIT_W-1:0]   iteration_limit,
   input  logic                          job_valid,
   output logic                          job_pop,
   input  met_pkg::job_type              job,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [met_pkg::RSP_W-1:0]     rsp_tdata   // pixel_column, pixel_row,
                                                     // escape_count, color_index
);
   import met_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_type;

   localparam logic signed [N_W-1:0] TWO_N  = N_W'(2) <<< FRAC_BITS;
   localparam logic signed [N_W-1:0] FOUR_N = N_W'(4) <<< FRAC_BITS;
   localparam logic signed [Z_W-1:0] TWO_Z  = Z_W'(2) <<< FRAC_BITS;

   state_type              state_ff, state_in;
   logic signed [Z_W-1:0]  zr_ff, zr_in, zi_ff, zi_in;
   logic signed [C_W-1:0]  cre_ff, cre_in, cim_ff, cim_in;
   logic [LIMIT_W-1:0]     n_ff, n_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [COORD_W-1:0]     col_ff, col_in, row_ff, row_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]       rsp_data_ff, rsp_data_in;

   logic signed [P_W-1:0]  prod_rr, prod_ii, prod_ri;
   logic signed [N_W-1:0]  sq_r, sq_i, dbl_ri, mag_sum, nr, ni;
   logic                   out_escape, box_fail;

   // (count mod 255) + 1, zero for a point that never escaped
   function automatic logic [COLOR_W-1:0] color_of(input logic [COUNT_W-1:0] count);
      logic [8:0] s;
      s = {1'b0, count[15:8]} + {1'b0, count[7:0]};
      if (s >= 9'd510) begin
         s = s - 9'd510;
      end else if (s >= 9'd255) begin
         s = s - 9'd255;
      end
      return (count == '0) ? '0 : COLOR_W'(s + 9'd1);
   endfunction

   // one complex step: three products, floored back to the fixed-point grid
   always_comb begin
      prod_rr    = zr_ff * zr_ff;
      prod_ii    = zi_ff * zi_ff;
      prod_ri    = zr_ff * zi_ff;
      sq_r       = N_W'(prod_rr >>> FRAC_BITS);
      sq_i       = N_W'(prod_ii >>> FRAC_BITS);
      dbl_ri     = N_W'(prod_ri >>> (FRAC_BITS - 1));
      mag_sum    = sq_r + sq_i;
      nr         = sq_r - sq_i + N_W'(cre_ff);
      ni         = dbl_ri + N_W'(cim_ff);
      out_escape = mag_sum > FOUR_N;
      box_fail   = (nr > TWO_N) || (nr < -TWO_N) || (ni > TWO_N) || (ni < -TWO_N);
   end

   always_comb begin
      state_in     = state_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      cre_in       = cre_ff;
      cim_in       = cim_ff;
      n_in         = n_ff;
      count_in     = count_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      job_pop      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               zr_in    = '0;
               zi_in    = '0;
               n_in     = '0;
               cre_in   = job.c_re;
               cim_in   = job.c_im;
               col_in   = job.column;
               row_in   = job.row;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (out_escape) begin
               // the magnitude test of the previous step fails
               count_in = n_ff;
               state_in = ST_DONE;
            end else if (n_ff == iteration_limit) begin
               count_in = '0;
               state_in = ST_DONE;
            end else if (box_fail) begin
               count_in = n_ff + COUNT_W'(1);
               state_in = ST_DONE;
            end else begin
               zr_in = Z_W'(nr);
               zi_in = Z_W'(ni);
               n_in  = n_ff + LIMIT_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {color_of(count_ff), count_ff, row_ff, col_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      zr_ff       <= zr_in;
      zi_ff       <= zi_in;
      cre_ff      <= cre_in;
      cim_ff      <= cim_in;
      n_ff        <= n_in;
      count_ff    <= count_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_color_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff[2*COORD_W +: COUNT_W] == '0) ==
                        (rsp_data_ff[2*COORD_W+COUNT_W +: COLOR_W] == '0)))
      else $error("colour and escape count disagree on escape");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> n_ff <= iteration_limit)
      else $error("step counter passed the iteration limit");

   a_z_in_box: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> (zr_ff <= TWO_Z && zr_ff >= -TWO_Z &&
                              zi_ff <= TWO_Z && zi_ff >= -TWO_Z))
      else $error("iterate outside the escape box while running");

endmodule
